### rtl/core/pqls_pkg.sv
package pqls_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int ENTRY_W  = VALUE_W + PRIO_W;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

### rtl/core/pqls_ram.sv
module pqls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/priority_queue_linear_scan.sv
// Enqueue: the result appears in the cycle after the transaction is accepted; busy stays low.
// Dequeue: a scan reads each held entry to find the highest priority, then a shift moves each
// entry after the winner down one place (none when the winner is the last entry); one entry
// memory read per cycle. A dequeue from an empty queue returns ST_EMPTY without a scan.
// Each result is shown for exactly one cycle on done; the receiver cannot stall it.
// Reset (asynchronous, active low) empties the queue; the entry memory is not cleared.
module priority_queue_linear_scan #(
    parameter int DEPTH = pqls_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic signed [pqls_pkg::VALUE_W-1:0] item_value,
    input  logic signed [pqls_pkg::PRIO_W-1:0]  item_priority,
    output logic                                done,
    output logic [pqls_pkg::STATUS_W-1:0]       status,
    output logic signed [pqls_pkg::VALUE_W-1:0] out_value,
    output logic                                now_empty,
    output logic [pqls_pkg::COUNT_W-1:0]        entry_count
);

    import pqls_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [AW-1:0]             rd_idx_reg, rd_idx_next;
    logic [AW-1:0]             best_idx_reg, best_idx_next;
    logic signed [PRIO_W-1:0]  best_p_reg, best_p_next;
    logic [VALUE_W-1:0]        best_val_reg, best_val_next;
    logic                      done_reg, done_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [VALUE_W-1:0]        out_value_reg, out_value_next;
    logic                      now_empty_reg, now_empty_next;
    logic [COUNT_W-1:0]        entry_count_reg, entry_count_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [ENTRY_W-1:0]        ram_rdata;

    logic                      accept;
    logic                      issue;
    logic                      take;
    logic signed [PRIO_W-1:0]  rd_prio;
    logic [AW-1:0]             cur_best_idx;

    pqls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign issue       = (rd_ptr_reg < count_reg);
    assign rd_prio     = signed'(ram_rdata[PRIO_W-1:0]);
    assign take        = rd_vld_reg && ((rd_idx_reg == '0) || (rd_prio > best_p_reg));
    assign cur_best_idx = take ? rd_idx_reg : best_idx_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_ptr_next      = rd_ptr_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = rd_idx_reg;
        best_idx_next    = best_idx_reg;
        best_p_next      = best_p_reg;
        best_val_next    = best_val_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        out_value_next   = out_value_reg;
        now_empty_next   = now_empty_reg;
        entry_count_next = entry_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[AW-1:0];
        ram_wdata        = {item_value, item_priority};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_ENQUEUE)
                    begin
                        done_next      = 1'b1;
                        out_value_next = '0;
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            ram_we      = 1'b1;
                            count_next  = count_reg + CW'(1);
                        end
                        now_empty_next   = (count_next == '0);
                        entry_count_next = COUNT_W'(count_next);
                    end
                    else if (count_reg == '0)
                    begin
                        done_next        = 1'b1;
                        status_next      = ST_EMPTY;
                        out_value_next   = '0;
                        now_empty_next   = 1'b1;
                        entry_count_next = '0;
                    end
                    else
                    begin
                        rd_ptr_next = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                rd_vld_next = issue;
                rd_idx_next = rd_ptr_reg[AW-1:0];
                if (take)
                begin
                    best_idx_next = rd_idx_reg;
                    best_p_next   = rd_prio;
                    best_val_next = ram_rdata[ENTRY_W-1:PRIO_W];
                end
                if (rd_vld_reg && (CW'(rd_idx_reg) == count_reg - CW'(1)))
                begin
                    rd_ptr_next = CW'(cur_best_idx) + CW'(1);
                    rd_vld_next = 1'b0;
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                rd_vld_next = issue;
                rd_idx_next = rd_ptr_reg[AW-1:0];
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (!issue && !rd_vld_reg)
                begin
                    count_next       = count_reg - CW'(1);
                    done_next        = 1'b1;
                    status_next      = ST_OK;
                    out_value_next   = best_val_reg;
                    now_empty_next   = (count_next == '0);
                    entry_count_next = COUNT_W'(count_next);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            rd_ptr_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= ST_OK;
            out_value_reg   <= '0;
            now_empty_reg   <= 1'b1;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            rd_ptr_reg      <= rd_ptr_next;
            rd_vld_reg      <= rd_vld_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            out_value_reg   <= out_value_next;
            now_empty_reg   <= now_empty_next;
            entry_count_reg <= entry_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_p_reg   <= best_p_next;
        best_val_reg <= best_val_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_value   = signed'(out_value_reg);
    assign now_empty   = now_empty_reg;
    assign entry_count = entry_count_reg;

endmodule

### rtl/core/pqls_checker.sv
module pqls_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [pqls_pkg::STATUS_W-1:0]       status,
    input logic signed [pqls_pkg::VALUE_W-1:0] out_value,
    input logic                                now_empty,
    input logic [pqls_pkg::COUNT_W-1:0]        entry_count
);

    import pqls_pkg::*;

    // A failed request never returns a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (out_value == '0))
        else $error("failed transaction returned a nonzero value");

    // An empty result always reports an empty queue with no entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY) |-> now_empty && (entry_count == '0))
        else $error("empty status with nonempty count");

    // A result that reports an empty queue always reports a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && now_empty |-> (entry_count == '0))
        else $error("empty flag disagrees with entry count");

    // A result is only given once the block has finished its work.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // Every result follows an accepted transaction or a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a transaction");

endmodule

bind priority_queue_linear_scan pqls_checker u_pqls_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .out_value   (out_value),
    .now_empty   (now_empty),
    .entry_count (entry_count)
);

### tb/priority_queue_linear_scan_tb.sv
`timescale 1ns / 100ps

module priority_queue_linear_scan_tb;
    import pqls_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_GAP = 11;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT = 1500000;

    localparam int PHASE_FILL = 0;
    localparam int PHASE_DRAIN = 1;
    localparam int PHASE_MIXED = 2;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } queue_entry_t;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic                      empty;
        logic [COUNT_W-1:0]        count;
    } queue_result_t;

    class pq_scoreboard;
        queue_entry_t  held_entries[$];
        queue_result_t awaited_results[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(logic req, logic signed [VALUE_W-1:0] val,
                                   logic signed [PRIO_W-1:0] pri);
            queue_result_t r;
            queue_entry_t  e;
            int            best;
            r.status = ST_OK;
            r.value = '0;
            if (req == REQ_ENQUEUE)
            begin
                if (held_entries.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    e.value = val;
                    e.prio = pri;
                    held_entries.push_back(e);
                end
            end
            else if (held_entries.size() == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                best = 0;
                for (int i = 1; i < held_entries.size(); i++)
                    if (held_entries[i].prio > held_entries[best].prio)
                        best = i;
                r.value = held_entries[best].value;
                held_entries.delete(best);
            end
            r.empty = (held_entries.size() == 0);
            r.count = COUNT_W'(held_entries.size());
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, longint expected, longint actual);
            if (expected != actual)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expected, actual);
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] val,
                                   logic empty, logic [COUNT_W-1:0] count);
            queue_result_t r;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                         $time, st, val);
                return;
            end
            r = awaited_results.pop_front();
            compare_field("status", r.status, st);
            compare_field("out_value", r.value, val);
            compare_field("now_empty", r.empty, empty);
            compare_field("entry_count", r.count, count);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      req_type = REQ_ENQUEUE;
    logic signed [VALUE_W-1:0] item_value = '0;
    logic signed [PRIO_W-1:0]  item_priority = '0;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] out_value;
    logic                      now_empty;
    logic [COUNT_W-1:0]        entry_count;

    int           cycle_count = 0;
    pq_scoreboard sb = new();

    priority_queue_linear_scan #(
        .DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .item_value(item_value),
        .item_priority(item_priority),
        .done(done),
        .status(status),
        .out_value(out_value),
        .now_empty(now_empty),
        .entry_count(entry_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(req_type, item_value, item_priority);
            if (done)
                sb.check_result(status, out_value, now_empty, entry_count);
        end
    end

    task automatic send_request(input logic req, input logic signed [VALUE_W-1:0] val,
                                input logic signed [PRIO_W-1:0] pri, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= req;
        item_value <= val;
        item_priority <= pri;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
        send_request(REQ_ENQUEUE, 32'sh7FFF_FFFF, -16'sd32768, 0);
        send_request(REQ_ENQUEUE, 32'sh8000_0000, 16'sd32767, 0);
        send_request(REQ_ENQUEUE, 32'sd0, 16'sd32767, 3);
        send_request(REQ_ENQUEUE, -32'sd1, 16'sd0, 0);
        send_request(REQ_ENQUEUE, 32'sd5, -16'sd1, 1);
        send_request(REQ_DEQUEUE, 32'shFFFF_FFFF, 16'shFFFF, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 5);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 2);
        send_request(REQ_ENQUEUE, 32'sd11, 16'sd7, 0);
        send_request(REQ_ENQUEUE, 32'sd22, 16'sd7, 0);
        send_request(REQ_ENQUEUE, 32'sd33, 16'sd7, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
        send_request(REQ_ENQUEUE, 32'sd44, 16'sd8, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 4);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
        send_request(REQ_DEQUEUE, 32'sd0, 16'sd0, 0);
    endtask

    task automatic run_random();
        int                       issued;
        int                       phase;
        int                       phase_len;
        int                       enqueue_pct;
        bit                       idle_on;
        logic                     req;
        logic signed [PRIO_W-1:0] pri;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            phase = $urandom_range(PHASE_MIXED, PHASE_FILL);
            phase_len = $urandom_range(240, 40);
            idle_on = $urandom_range(3, 0) != 0;
            case (phase)
                PHASE_FILL: enqueue_pct = 85;
                PHASE_DRAIN: enqueue_pct = 15;
                default: enqueue_pct = 50;
            endcase
            for (int n = 0; n < phase_len && issued < RANDOM_ITEMS; n++)
            begin
                req = ($urandom_range(99, 0) < enqueue_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
                if ($urandom_range(1, 0) != 0)
                    pri = PRIO_W'($urandom_range(8, 0)) - 16'sd4;
                else
                    pri = PRIO_W'($urandom);
                send_request(req, VALUE_W'($urandom), pri,
                             idle_on ? $urandom_range(MAX_GAP, 0) : 0);
                issued++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        start <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
